// File: hw/rtl/tsms_pkg.sv
// shared types and codes for the two stepper move sequencer
package tsms_pkg;

    localparam int unsigned STEP_W  = 16;
    localparam int unsigned PHASE_W = 2;
    localparam int unsigned DIR_W   = 4;
    localparam int unsigned MODE_W  = 2;
    localparam int unsigned ADDR_W  = 4;
    localparam int unsigned DATA_W  = 32;

    // item kinds
    localparam logic [MODE_W-1:0] MODE_SET    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RIGHT  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LEFT   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    // move directions
    localparam logic [DIR_W-1:0] DIR_STOP  = 4'd0;
    localparam logic [DIR_W-1:0] DIR_FWD   = 4'd1;
    localparam logic [DIR_W-1:0] DIR_BACK  = 4'd2;
    localparam logic [DIR_W-1:0] DIR_LEFT  = 4'd3;
    localparam logic [DIR_W-1:0] DIR_RIGHT = 4'd4;
    localparam logic [DIR_W-1:0] DIR_TURN  = 4'd5;
    localparam logic [DIR_W-1:0] DIR_RFORE = 4'd6;
    localparam logic [DIR_W-1:0] DIR_RBACK = 4'd7;
    localparam logic [DIR_W-1:0] DIR_LFORE = 4'd8;
    localparam logic [DIR_W-1:0] DIR_LBACK = 4'd9;

    // phase steps
    localparam logic [PHASE_W-1:0] PHASE_FWD = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_REV = 2'd3;

    // register indexes
    localparam logic [1:0] REG_FORWARD    = 2'd0;
    localparam logic [1:0] REG_LEFT_TURN  = 2'd1;
    localparam logic [1:0] REG_RIGHT_TURN = 2'd2;
    localparam logic [1:0] REG_ABOUT_TURN = 2'd3;

    typedef struct packed {
        logic [STEP_W-1:0] forward_steps;
        logic [STEP_W-1:0] left_turn_steps;
        logic [STEP_W-1:0] right_turn_steps;
        logic [STEP_W-1:0] about_turn_steps;
    } t_cfg;

    typedef struct packed {
        logic [DIR_W-1:0]   direction;
        logic [STEP_W-1:0]  step_count;
        logic [PHASE_W-1:0] right_index;
        logic [PHASE_W-1:0] left_index;
    } t_state;

    typedef struct packed {
        logic [PHASE_W-1:0] right_phase;
        logic [PHASE_W-1:0] left_phase;
        logic [DIR_W-1:0]   direction_now;
        logic               move_done;
        logic               restore_period;
    } t_result;

endpackage

// File: hw/rtl/tsms_cfg_regs.sv
// step limit registers behind the apb-style port
module tsms_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tsms_pkg::ADDR_W-1:0]   paddr,
    input  logic [tsms_pkg::DATA_W-1:0]   pwdata,
    output logic [tsms_pkg::DATA_W-1:0]   prdata,
    output tsms_pkg::t_cfg                o_cfg
);

    tsms_pkg::t_cfg r_cfg;
    logic           wr_en;
    logic [1:0]     reg_idx;
    logic [tsms_pkg::STEP_W-1:0] rd_val;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                tsms_pkg::REG_FORWARD:    r_cfg.forward_steps    <= pwdata[15:0];
                tsms_pkg::REG_LEFT_TURN:  r_cfg.left_turn_steps  <= pwdata[15:0];
                tsms_pkg::REG_RIGHT_TURN: r_cfg.right_turn_steps <= pwdata[15:0];
                tsms_pkg::REG_ABOUT_TURN: r_cfg.about_turn_steps <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            tsms_pkg::REG_FORWARD:    rd_val = r_cfg.forward_steps;
            tsms_pkg::REG_LEFT_TURN:  rd_val = r_cfg.left_turn_steps;
            tsms_pkg::REG_RIGHT_TURN: rd_val = r_cfg.right_turn_steps;
            tsms_pkg::REG_ABOUT_TURN: rd_val = r_cfg.about_turn_steps;
            default:                  rd_val = '0;
        endcase
    end

    assign prdata = {{(tsms_pkg::DATA_W-tsms_pkg::STEP_W){1'b0}}, rd_val};
    assign o_cfg  = r_cfg;

endmodule

// File: hw/rtl/tsms_step_logic.sv
// next state and result for one command or tick
module tsms_step_logic (
    input  tsms_pkg::t_cfg                i_cfg,
    input  tsms_pkg::t_state              i_state,
    input  logic [tsms_pkg::MODE_W-1:0]   i_mode,
    input  logic [tsms_pkg::DIR_W-1:0]    i_new_direction,
    output tsms_pkg::t_state              o_next,
    output tsms_pkg::t_result             o_result
);

    logic [tsms_pkg::STEP_W-1:0] cnt_inc;
    logic [tsms_pkg::STEP_W-1:0] limit;
    logic                        hit;
    logic                        done;
    logic                        restore;
    tsms_pkg::t_state            nxt;

    assign cnt_inc = i_state.step_count + 16'd1;

    // limit of the counted move in progress
    always_comb begin
        unique case (i_state.direction)
            tsms_pkg::DIR_FWD:   limit = i_cfg.forward_steps;
            tsms_pkg::DIR_LEFT:  limit = i_cfg.left_turn_steps;
            tsms_pkg::DIR_RIGHT: limit = i_cfg.right_turn_steps;
            tsms_pkg::DIR_TURN:  limit = i_cfg.about_turn_steps;
            default:             limit = '0;
        endcase
    end

    assign hit = (cnt_inc == limit);

    always_comb begin
        nxt     = i_state;
        done    = 1'b0;
        restore = 1'b0;
        unique case (i_mode)
            tsms_pkg::MODE_SET: begin
                nxt.direction = (i_new_direction > tsms_pkg::DIR_LBACK) ?
                                tsms_pkg::DIR_STOP : i_new_direction;
            end
            tsms_pkg::MODE_RIGHT: begin
                unique case (i_state.direction) inside
                    tsms_pkg::DIR_FWD, tsms_pkg::DIR_LEFT: begin
                        nxt.right_index = i_state.right_index + tsms_pkg::PHASE_FWD;
                        nxt.step_count  = cnt_inc;
                        if (hit) begin
                            nxt.direction  = tsms_pkg::DIR_STOP;
                            nxt.step_count = '0;
                            done           = 1'b1;
                            restore        = (i_state.direction == tsms_pkg::DIR_FWD);
                        end
                    end
                    tsms_pkg::DIR_RIGHT, tsms_pkg::DIR_TURN: begin
                        nxt.right_index = i_state.right_index + tsms_pkg::PHASE_REV;
                        nxt.step_count  = cnt_inc;
                        if (hit) begin
                            nxt.direction  = tsms_pkg::DIR_STOP;
                            nxt.step_count = '0;
                            done           = 1'b1;
                        end
                    end
                    tsms_pkg::DIR_BACK: begin
                        // counts but never stops, wraps at 16 bits
                        nxt.right_index = i_state.right_index + tsms_pkg::PHASE_REV;
                        nxt.step_count  = cnt_inc;
                    end
                    tsms_pkg::DIR_RFORE: begin
                        nxt.right_index = i_state.right_index + tsms_pkg::PHASE_FWD;
                        nxt.direction   = tsms_pkg::DIR_STOP;
                    end
                    tsms_pkg::DIR_RBACK: begin
                        nxt.right_index = i_state.right_index + tsms_pkg::PHASE_REV;
                        nxt.direction   = tsms_pkg::DIR_STOP;
                    end
                    default: ;
                endcase
            end
            tsms_pkg::MODE_LEFT: begin
                unique case (i_state.direction) inside
                    tsms_pkg::DIR_FWD, tsms_pkg::DIR_RIGHT, tsms_pkg::DIR_TURN: begin
                        nxt.left_index = i_state.left_index + tsms_pkg::PHASE_FWD;
                    end
                    tsms_pkg::DIR_BACK, tsms_pkg::DIR_LEFT: begin
                        nxt.left_index = i_state.left_index + tsms_pkg::PHASE_REV;
                    end
                    tsms_pkg::DIR_LFORE: begin
                        nxt.left_index = i_state.left_index + tsms_pkg::PHASE_FWD;
                        nxt.direction  = tsms_pkg::DIR_STOP;
                    end
                    tsms_pkg::DIR_LBACK: begin
                        nxt.left_index = i_state.left_index + tsms_pkg::PHASE_REV;
                        nxt.direction  = tsms_pkg::DIR_STOP;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    assign o_next                  = nxt;
    assign o_result.right_phase    = nxt.right_index;
    assign o_result.left_phase     = nxt.left_index;
    assign o_result.direction_now  = nxt.direction;
    assign o_result.move_done      = done;
    assign o_result.restore_period = restore;

endmodule

// File: hw/rtl/tsms_out_fifo.sv
// two-entry result buffer between the step logic and the output channel
module tsms_out_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  tsms_pkg::t_result  i_data,
    output logic               o_full,
    output logic               o_valid,
    input  logic               i_pop,
    output tsms_pkg::t_result  o_data
);

    tsms_pkg::t_result r_mem [2];
    logic              r_wr_ptr;
    logic              r_rd_ptr;
    logic [1:0]        r_count;
    logic              n_wr_ptr;
    logic              n_rd_ptr;
    logic [1:0]        n_count;
    logic              do_pop;

    assign do_pop = i_pop && (r_count != 2'd0);

    always_comb begin
        n_wr_ptr = i_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = do_pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + {1'b0, i_push} - {1'b0, do_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];

endmodule

// File: hw/rtl/two_stepper_move_sequencer_core.sv
// top level of the two stepper move sequencer
//
//   channel   direction  handshake            payload
//   input     in         i_valid / o_ready    i_mode, i_new_direction
//   result    out        o_valid / i_ready    o_right_phase, o_left_phase,
//                                             o_direction_now, o_move_done,
//                                             o_restore_period
//   config    in         psel/penable/pready  paddr, pwrite, pwdata, prdata
//
// one item per cycle while o_ready is high; the result is registered in the result buffer when the item is taken
// state is updated in the same edge that takes the item, so back to back items
//   see each other with no gap; the cost per item is one 16-bit add and compare
// results queue in a two-entry buffer, so an item is taken while one result
//   still waits; o_ready drops only when both entries are held
// synchronous active-low reset clears direction, step count, both phases,
//   the step limits and the buffer; no clearing pass is needed
module two_stepper_move_sequencer_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input channel
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [tsms_pkg::MODE_W-1:0]   i_mode,
    input  logic [tsms_pkg::DIR_W-1:0]    i_new_direction,
    // result channel
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [tsms_pkg::PHASE_W-1:0]  o_right_phase,
    output logic [tsms_pkg::PHASE_W-1:0]  o_left_phase,
    output logic [tsms_pkg::DIR_W-1:0]    o_direction_now,
    output logic                          o_move_done,
    output logic                          o_restore_period,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tsms_pkg::ADDR_W-1:0]   paddr,
    input  logic [tsms_pkg::DATA_W-1:0]   pwdata,
    output logic [tsms_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    tsms_pkg::t_cfg    cfg;
    tsms_pkg::t_state  r_state;
    tsms_pkg::t_state  n_state;
    tsms_pkg::t_result step_res;
    tsms_pkg::t_result out_res;
    logic              fifo_full;
    logic              accept;

    // register file for the four step limits, zero-wait writes
    assign pready = 1'b1;

    tsms_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (cfg)
    );

    // an item is taken whenever the result buffer has a free entry
    assign o_ready = !fifo_full;
    assign accept  = i_valid && o_ready;

    // all per-item work: phase advance, step count, stop decision
    tsms_step_logic u_step (
        .i_cfg           (cfg),
        .i_state         (r_state),
        .i_mode          (i_mode),
        .i_new_direction (i_new_direction),
        .o_next          (n_state),
        .o_result        (step_res)
    );

    // motor state: direction, step counter and both phase indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    // result buffer toward the output channel
    tsms_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (step_res),
        .o_full  (fifo_full),
        .o_valid (o_valid),
        .i_pop   (i_ready),
        .o_data  (out_res)
    );

    assign o_right_phase    = out_res.right_phase;
    assign o_left_phase     = out_res.left_phase;
    assign o_direction_now  = out_res.direction_now;
    assign o_move_done      = out_res.move_done;
    assign o_restore_period = out_res.restore_period;

endmodule

// File: hw/rtl/tsms_checker.sv
// port-level checks for the sequencer core, bound to the top level
module tsms_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic [tsms_pkg::PHASE_W-1:0]  o_right_phase,
    input logic [tsms_pkg::PHASE_W-1:0]  o_left_phase,
    input logic [tsms_pkg::DIR_W-1:0]    o_direction_now,
    input logic                          o_move_done,
    input logic                          o_restore_period
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_right_phase) &&
        $stable(o_left_phase) && $stable(o_direction_now) &&
        $stable(o_move_done) && $stable(o_restore_period))
        else $error("result changed while stalled");

    // no result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // period restore only comes with the end of a counted move
    a_restore_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_restore_period |-> o_move_done)
        else $error("restore without move done");

    // a finished move leaves the motors stopped
    a_done_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_move_done |-> o_direction_now == tsms_pkg::DIR_STOP)
        else $error("move done but direction not stop");

endmodule

bind two_stepper_move_sequencer_core tsms_checker u_tsms_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_right_phase    (o_right_phase),
    .o_left_phase     (o_left_phase),
    .o_direction_now  (o_direction_now),
    .o_move_done      (o_move_done),
    .o_restore_period (o_restore_period)
);
